>>> src/fst_pkg.sv
// ----------------------------------------------------------------------------
// fst_pkg
// Shared types and constants of the frame / SNAC / block parser.
// ----------------------------------------------------------------------------
package fst_pkg;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SNAC   = 2'd1,
    KIND_VALUE  = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    PH_HEADER    = 5'b00001,
    PH_SNAC      = 5'b00010,
    PH_BLOCK_HDR = 5'b00100,
    PH_VALUE     = 5'b01000,
    PH_DROP      = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  marker_byte;
    logic [7:0]  channel;
    logic [15:0] sequence_res;
    logic [15:0] frame_length;
    logic [15:0] snac_family;
    logic [15:0] snac_subtype;
    logic [15:0] snac_flags;
    logic [31:0] request_id;
    logic [15:0] block_type;
    logic [7:0]  value_byte;
    logic        last_of_block;
  } result_t;

endpackage

>>> src/fst_byte_if.sv
// ----------------------------------------------------------------------------
// fst_byte_if / fst_result_if
// Valid/ready channels of the parser: input bytes and result items.
// ----------------------------------------------------------------------------
interface fst_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface fst_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  marker_byte;
  logic [7:0]  channel;
  logic [15:0] sequence_res;
  logic [15:0] frame_length;
  logic [15:0] snac_family;
  logic [15:0] snac_subtype;
  logic [15:0] snac_flags;
  logic [31:0] request_id;
  logic [15:0] block_type;
  logic [7:0]  value_byte;
  logic        last_of_block;
  modport source (output valid, output kind, output marker_byte, output channel,
                  output sequence_res, output frame_length, output snac_family,
                  output snac_subtype, output snac_flags, output request_id,
                  output block_type, output value_byte, output last_of_block,
                  input ready);
  modport sink   (input valid, input kind, input marker_byte, input channel,
                  input sequence_res, input frame_length, input snac_family,
                  input snac_subtype, input snac_flags, input request_id,
                  input block_type, input value_byte, input last_of_block,
                  output ready);
endinterface

>>> src/fst_front.sv
// ----------------------------------------------------------------------------
// fst_front
// Byte parser: tracks frame, SNAC and block state and builds result requests.
// ----------------------------------------------------------------------------
module fst_front
  import fst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] connect_marker,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  output logic        in_ready,
  input  logic        q_ready,
  output logic        res_valid,
  output result_t     res
);

  phase_t      phase, phase_next;
  logic [3:0]  field_count, field_count_next;
  logic [47:0] header_regs, header_regs_next;
  logic [15:0] payload_left, payload_left_next, pl_dec;
  logic [47:0] snac_regs, snac_regs_next, keep;
  logic [31:0] id_reg, id_reg_next;
  logic [15:0] cur_type, cur_type_next;
  logic [15:0] block_left, block_left_next, bl_dec;
  logic [4:0]  n;
  logic        emit;
  kind_t       kind;
  logic        last;
  logic        fire;

  assign in_ready = q_ready;
  assign fire     = in_valid && in_ready;
  assign pl_dec   = payload_left - 16'd1;
  assign bl_dec   = block_left - 16'd1;

  // next-state logic, one byte per request
  always_comb begin
    phase_next       = phase;
    field_count_next = field_count;
    header_regs_next = header_regs;
    payload_left_next = payload_left;
    snac_regs_next   = snac_regs;
    id_reg_next      = id_reg;
    cur_type_next    = cur_type;
    block_left_next  = block_left;
    emit = 1'b0;
    kind = KIND_HEADER;
    last = 1'b0;
    n    = {1'b0, field_count} + 5'd1;
    keep = '0;
    unique case (phase)
      PH_SNAC: begin
        payload_left_next = pl_dec;
        if (field_count < 4'd6)
          snac_regs_next[8*(5-field_count[2:0]) +: 8] = in_byte;
        else if (field_count < 4'd10)
          id_reg_next[8*(9-field_count) +: 8] = in_byte;
        if (n == 5'd4 && snac_regs_next[47:16] == connect_marker) begin
          snac_regs_next   = '0;
          id_reg_next      = '0;
          field_count_next = '0;
          phase_next = (pl_dec != 16'd0) ? PH_BLOCK_HDR : PH_HEADER;
        end else if (n >= 5'd10 || pl_dec == 16'd0) begin
          if (n >= 5'd2) keep[47:32] = 16'hFFFF;
          if (n >= 5'd4) keep[31:16] = 16'hFFFF;
          if (n >= 5'd5) keep[15:8]  = 8'hFF;
          if (n >= 5'd6) keep[7:0]   = 8'hFF;
          snac_regs_next = snac_regs_next & keep;
          if (n < 5'd10) id_reg_next = '0;
          field_count_next = '0;
          phase_next = (pl_dec != 16'd0) ? PH_BLOCK_HDR : PH_HEADER;
          emit = 1'b1;
          kind = KIND_SNAC;
        end else begin
          field_count_next = n[3:0];
        end
      end
      PH_BLOCK_HDR: begin
        payload_left_next = pl_dec;
        if (field_count == 4'd0 && pl_dec < 16'd3) begin
          phase_next = (pl_dec != 16'd0) ? PH_DROP : PH_HEADER;
        end else begin
          if (field_count < 4'd2) cur_type_next = {cur_type[7:0], in_byte};
          else block_left_next = {block_left[7:0], in_byte};
          if (pl_dec == 16'd0) begin
            field_count_next = '0;
            phase_next = PH_HEADER;
          end else if (n >= 5'd4) begin
            field_count_next = '0;
            phase_next = (block_left_next != 16'd0) ? PH_VALUE : PH_BLOCK_HDR;
          end else begin
            field_count_next = n[3:0];
          end
        end
      end
      PH_VALUE: begin
        payload_left_next = pl_dec;
        block_left_next   = bl_dec;
        last = (bl_dec == 16'd0) || (pl_dec == 16'd0);
        emit = 1'b1;
        kind = KIND_VALUE;
        field_count_next = '0;
        if (pl_dec == 16'd0) phase_next = PH_HEADER;
        else if (bl_dec == 16'd0) phase_next = PH_BLOCK_HDR;
      end
      PH_DROP: begin
        payload_left_next = pl_dec;
        if (pl_dec == 16'd0) begin
          field_count_next = '0;
          phase_next = PH_HEADER;
        end
      end
      default: begin
        header_regs_next = {header_regs[39:0], in_byte};
        if (n < 5'd6) begin
          field_count_next = n[3:0];
          phase_next = PH_HEADER;
        end else begin
          field_count_next  = '0;
          payload_left_next = header_regs_next[15:0];
          snac_regs_next    = '0;
          id_reg_next       = '0;
          phase_next = (header_regs_next[15:0] != 16'd0) ? PH_SNAC : PH_HEADER;
          emit = 1'b1;
        end
      end
    endcase
  end

  // result request built from the updated state
  always_comb begin
    res.kind          = kind;
    res.marker_byte   = header_regs_next[47:40];
    res.channel       = header_regs_next[39:32];
    res.sequence_res  = header_regs_next[31:16];
    res.frame_length  = header_regs_next[15:0];
    res.snac_family   = snac_regs_next[47:32];
    res.snac_subtype  = snac_regs_next[31:16];
    res.snac_flags    = snac_regs_next[15:0];
    res.request_id    = id_reg_next;
    res.block_type    = (kind == KIND_VALUE) ? cur_type : 16'd0;
    res.value_byte    = (kind == KIND_VALUE) ? in_byte : 8'd0;
    res.last_of_block = last;
  end
  assign res_valid = fire && emit;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      field_count  <= '0;
      header_regs  <= '0;
      payload_left <= '0;
      snac_regs    <= '0;
      id_reg       <= '0;
      cur_type     <= '0;
      block_left   <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      field_count  <= field_count_next;
      header_regs  <= header_regs_next;
      payload_left <= payload_left_next;
      snac_regs    <= snac_regs_next;
      id_reg       <= id_reg_next;
      cur_type     <= cur_type_next;
      block_left   <= block_left_next;
    end
  end

endmodule

>>> src/fst_queue.sv
// ----------------------------------------------------------------------------
// fst_queue
// Short result queue between parser and output channel.
// ----------------------------------------------------------------------------
module fst_queue
  import fst_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t wr_data,
  output logic    space,
  output logic    rd_valid,
  input  logic    rd_en,
  output result_t rd_data
);

  result_t              mem [QueueDepth];
  logic [QueuePtrW-1:0] wp, rp;
  logic [QueueCntW-1:0] count;

  assign space    = (count != QueueCntW'(QueueDepth)) || rd_en;
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rp];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr_en) wp <= (wp == QueuePtrW'(QueueDepth - 1)) ? '0 : wp + 1'b1;
      if (rd_en) rp <= (rp == QueuePtrW'(QueueDepth - 1)) ? '0 : rp + 1'b1;
      count <= count + QueueCntW'(wr_en) - QueueCntW'(rd_en);
    end
  end

endmodule

>>> src/flap_snac_tlv_parser.sv
// ----------------------------------------------------------------------------
// flap_snac_tlv_parser
// Frame header, SNAC header and value block parser for a byte stream.
// ----------------------------------------------------------------------------
// One byte is taken every cycle while the input is not stalled; the parser
// state updates in the same cycle and any result request enters a two-entry
// queue, from which it leaves once the output takes it. Input stalls only
// while that queue is full and the output is not taken.
module flap_snac_tlv_parser
  import fst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  fst_byte_if.sink    in_ch,
  fst_result_if.source out_ch
);

  logic [31:0] connect_marker;
  logic        q_space, res_valid, rd_valid;
  result_t     res, rd_data;

  // connect marker register
  always_ff @(posedge clk) begin
    if (rst) connect_marker <= 32'd1;
    else if (cfg_we) connect_marker <= cfg_wdata;
  end

  fst_front u_front (
    .clk, .rst, .connect_marker,
    .in_valid(in_ch.valid), .in_byte(in_ch.in_byte), .in_ready(in_ch.ready),
    .q_ready(q_space), .res_valid, .res
  );

  fst_queue u_queue (
    .clk, .rst, .wr_en(res_valid), .wr_data(res), .space(q_space),
    .rd_valid, .rd_en(rd_valid && out_ch.ready), .rd_data
  );

  // output channel
  assign out_ch.valid         = rd_valid;
  assign out_ch.kind          = rd_data.kind;
  assign out_ch.marker_byte   = rd_data.marker_byte;
  assign out_ch.channel       = rd_data.channel;
  assign out_ch.sequence_res  = rd_data.sequence_res;
  assign out_ch.frame_length  = rd_data.frame_length;
  assign out_ch.snac_family   = rd_data.snac_family;
  assign out_ch.snac_subtype  = rd_data.snac_subtype;
  assign out_ch.snac_flags    = rd_data.snac_flags;
  assign out_ch.request_id    = rd_data.request_id;
  assign out_ch.block_type    = rd_data.block_type;
  assign out_ch.value_byte    = rd_data.value_byte;
  assign out_ch.last_of_block = rd_data.last_of_block;

endmodule

>>> dv/flap_snac_tlv_parser_tb.sv
// ----------------------------------------------------------------------------
// flap_snac_tlv_parser_tb
// Drives byte streams of frames into the parser and checks every result
// request against an in-bench model of the frame, SNAC and block decoding.
// ----------------------------------------------------------------------------
module flap_snac_tlv_parser_tb
  import fst_pkg::*;
();

  localparam int WatchdogLimit = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  fst_byte_if   in_ch ();
  fst_result_if out_ch ();

  flap_snac_tlv_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model state
  logic [31:0] mdl_marker;
  logic [2:0]  mdl_phase;
  logic [3:0]  mdl_count;
  logic [47:0] mdl_hdr;
  logic [15:0] mdl_left;
  logic [47:0] mdl_snac;
  logic [31:0] mdl_id;
  logic [15:0] mdl_type;
  logic [15:0] mdl_blk;

  localparam logic [2:0] MP_HEADER = 3'd0;
  localparam logic [2:0] MP_SNAC   = 3'd1;
  localparam logic [2:0] MP_BHDR   = 3'd2;
  localparam logic [2:0] MP_VALUE  = 3'd3;
  localparam logic [2:0] MP_DROP   = 3'd4;

  result_t expected_results[$];
  int      errors = 0;
  int      send_idle = 0;
  int      recv_stall = 0;
  int      quiet_cycles = 0;

  function automatic result_t make_result(kind_t k, logic [15:0] t, logic [7:0] v, logic l);
    result_t r;
    r.kind          = k;
    r.marker_byte   = mdl_hdr[47:40];
    r.channel       = mdl_hdr[39:32];
    r.sequence_res  = mdl_hdr[31:16];
    r.frame_length  = mdl_hdr[15:0];
    r.snac_family   = mdl_snac[47:32];
    r.snac_subtype  = mdl_snac[31:16];
    r.snac_flags    = mdl_snac[15:0];
    r.request_id    = mdl_id;
    r.block_type    = t;
    r.value_byte    = v;
    r.last_of_block = l;
    return r;
  endfunction

  // append one expected result at the tail
  function automatic void queue_expected(result_t r);
    expected_results = {expected_results, r};
  endfunction

  // parser model: one byte in, at most one result queued
  task automatic decode_byte(input logic [7:0] b);
    int i;
    int n;
    logic [47:0] keep;
    logic last;
    if (mdl_phase > MP_DROP) mdl_phase = MP_HEADER;
    if (mdl_phase == MP_HEADER) begin
      mdl_hdr = {mdl_hdr[39:0], b};
      n = mdl_count + 1;
      if (n < 6) begin
        mdl_count = 4'(n);
      end else begin
        mdl_count = '0;
        mdl_left = mdl_hdr[15:0];
        mdl_snac = '0;
        mdl_id = '0;
        mdl_phase = (mdl_left != 0) ? MP_SNAC : MP_HEADER;
        queue_expected(make_result(KIND_HEADER, '0, '0, 1'b0));
      end
      return;
    end
    mdl_left = mdl_left - 16'd1;
    case (mdl_phase)
      MP_SNAC: begin
        i = mdl_count;
        if (i < 6) mdl_snac[8*(5-i) +: 8] = b;
        else if (i < 10) mdl_id[8*(9-i) +: 8] = b;
        n = i + 1;
        if (n == 4 && mdl_snac[47:16] == mdl_marker) begin
          mdl_snac = '0;
          mdl_id = '0;
          mdl_count = '0;
          mdl_phase = (mdl_left != 0) ? MP_BHDR : MP_HEADER;
        end else if (n >= 10 || mdl_left == 0) begin
          keep = '0;
          if (n >= 2) keep[47:32] = '1;
          if (n >= 4) keep[31:16] = '1;
          if (n >= 5) keep[15:8] = '1;
          if (n >= 6) keep[7:0] = '1;
          mdl_snac &= keep;
          if (n < 10) mdl_id = '0;
          mdl_count = '0;
          mdl_phase = (mdl_left != 0) ? MP_BHDR : MP_HEADER;
          queue_expected(make_result(KIND_SNAC, '0, '0, 1'b0));
        end else begin
          mdl_count = 4'(n);
        end
      end
      MP_BHDR: begin
        i = mdl_count;
        if (i == 0 && mdl_left < 3) begin
          mdl_phase = (mdl_left != 0) ? MP_DROP : MP_HEADER;
        end else begin
          if (i < 2) mdl_type = {mdl_type[7:0], b};
          else mdl_blk = {mdl_blk[7:0], b};
          n = i + 1;
          if (mdl_left == 0) begin
            mdl_count = '0;
            mdl_phase = MP_HEADER;
          end else if (n >= 4) begin
            mdl_count = '0;
            mdl_phase = (mdl_blk != 0) ? MP_VALUE : MP_BHDR;
          end else begin
            mdl_count = 4'(n);
          end
        end
      end
      MP_VALUE: begin
        mdl_blk = mdl_blk - 16'd1;
        last = (mdl_blk == 0) || (mdl_left == 0);
        queue_expected(make_result(KIND_VALUE, mdl_type, b, last));
        mdl_count = '0;
        if (mdl_left == 0) mdl_phase = MP_HEADER;
        else if (mdl_blk == 0) mdl_phase = MP_BHDR;
      end
      default: begin
        if (mdl_left == 0) begin
          mdl_count = '0;
          mdl_phase = MP_HEADER;
        end
      end
    endcase
  endtask

  // send one byte request, idling first at the current rate
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b);
  endtask

  task automatic send_word16(input logic [15:0] w);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  // wait until all results are in, then let the block settle before a write
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_marker(input logic [31:0] m);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_marker = m;
  endtask

  // one frame: header, optional connect marker, up to ten further bytes, then blocks or raw bytes
  task automatic send_frame(input int plen, input bit connect, input bit tidy);
    int left;
    int blen;
    int k;
    send_byte(8'($urandom_range(255)));
    send_byte(8'($urandom_range(255)));
    send_word16(16'($urandom));
    send_word16(plen[15:0]);
    left = plen;
    if (connect && left >= 4) begin
      send_word16(mdl_marker[31:16]);
      send_word16(mdl_marker[15:0]);
      left -= 4;
    end
    k = (left < 10) ? left : 10;
    repeat (k) send_byte(8'($urandom_range(255)));
    left -= k;
    while (left > 0) begin
      if (tidy && left >= 4) begin
        blen = $urandom_range(0, left - 4 < 6 ? left - 4 : 6);
        if ($urandom_range(9) == 0) blen = $urandom_range(0, 12);
        send_word16(16'($urandom));
        send_word16(blen[15:0]);
        left -= 4;
      end else begin
        send_byte(8'($urandom_range(255)));
        left--;
      end
    end
  endtask

  task automatic test_directed;
    send_frame(0, 1'b0, 1'b1);
    send_byte(8'hFF); send_byte(8'hFF); send_word16(16'hFFFF); send_word16(16'd1);
    send_byte(8'hFF);
    send_frame(3, 1'b0, 1'b1);
    send_frame(6, 1'b0, 1'b1);
    send_frame(4, 1'b1, 1'b1);
    send_frame(18, 1'b1, 1'b1);
  endtask

  task automatic test_blocks;
    send_byte(8'h00); send_byte(8'h05); send_word16(16'h0000); send_word16(16'd25);
    repeat (10) send_byte(8'hAA);
    send_word16(16'h1234); send_word16(16'd0);
    send_word16(16'hFFFF); send_word16(16'd2); send_byte(8'h00); send_byte(8'hFF);
    send_word16(16'h0001); send_word16(16'd9); send_byte(8'h55);
  endtask

  task automatic test_random(input int frames);
    int plen;
    repeat (frames) begin
      plen = ($urandom_range(15) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 24);
      send_frame(plen, $urandom_range(2) == 0, $urandom_range(9) != 0);
    end
  endtask

  task automatic set_idling(input int s, input int r);
    send_idle  = s;
    recv_stall = r;
  endtask

  // receiver: random stalls, compare each result with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t exp_r;
    out_ch.ready <= !rst && ($urandom_range(99) >= recv_stall);
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.kind, out_ch.marker_byte, out_ch.channel, out_ch.sequence_res,
              out_ch.frame_length, out_ch.snac_family, out_ch.snac_subtype,
              out_ch.snac_flags, out_ch.request_id, out_ch.block_type,
              out_ch.value_byte, out_ch.last_of_block};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch, expected %h, actual %h", $time, exp_r, got);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving either way
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("flap_snac_tlv_parser_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    mdl_marker = 32'd1;
    mdl_phase = MP_HEADER;
    mdl_count = '0;
    mdl_hdr = '0;
    mdl_left = '0;
    mdl_snac = '0;
    mdl_id = '0;
    mdl_type = '0;
    mdl_blk = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_blocks();
    set_idling(0, 0);
    test_random(20);
    write_marker(32'h0000_0000);
    set_idling(68, 0);
    test_random(20);
    write_marker(32'hFFFF_FFFF);
    set_idling(0, 68);
    test_random(20);
    write_marker($urandom);
    set_idling(8, 8);
    test_random(20);
    write_marker(32'h0000_0001);
    set_idling(0, 0);
    test_random(6);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("flap_snac_tlv_parser_tb: done, clean");
    end else begin
      $display("flap_snac_tlv_parser_tb: done, errors");
    end
    $finish;
  end

endmodule
